// ----- design/aarm_pkg.sv -----
package aarm_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_BITS_DEF     = 14;

  // square root of |a|^2 * 2^30 fits in 31 bits
  localparam int SQRT_STEPS = 31;

  localparam longint PI_Q29         = 64'sd1686629713;
  localparam longint HALFPI_Q29     = 64'sd843314857;
  localparam longint TWOPI_Q29      = 64'sd3373259426;
  localparam longint KINF_Q30       = 64'sd652032874;
  localparam longint KTWOTHIRDS_Q30 = 64'sd434688583;
  localparam int     ONE_Q14        = 16384;

  // atan(2^-i) in Q30
  localparam longint ATAN_Q30 [0:23] = '{
    64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
    64'sd67021687,  64'sd33543516,  64'sd16775851,  64'sd8388437,
    64'sd4194283,   64'sd2097149,   64'sd1048576,   64'sd524288,
    64'sd262144,    64'sd131072,    64'sd65536,     64'sd32768,
    64'sd16384,     64'sd8192,      64'sd4096,      64'sd2048,
    64'sd1024,      64'sd512,       64'sd256,       64'sd128
  };

  // change fraction bits of a constant, rounding half up
  function automatic longint rescale_const(longint v, int from, int to);
    longint one;
    one = 64'sd1;
    if (to >= from) begin
      return v <<< (to - from);
    end
    return (v + (one <<< (from - to - 1))) >>> (from - to);
  endfunction

  // cordic gain in Q30 for a given stage count
  function automatic longint cordic_gain(int stages);
    longint one;
    one = 64'sd1;
    return KINF_Q30 + ((KTWOTHIRDS_Q30 + (one <<< (2 * stages - 1))) >>> (2 * stages));
  endfunction

endpackage

// ----- design/axis_angle_rotation_matrix_core.sv -----
// Rodrigues rotation matrix core: takes an axis (three signed 16-bit integers, any length)
// and an angle (signed Q4.12 radians) and returns the 3x3 rotation matrix in signed Q2.14,
// each entry saturated to plus or minus one. A zero-length axis gives the zero matrix with
// zero_axis set. The core accepts one word per clock while the output is not stalled and
// keeps a full pipeline whose depth is set mostly by the 31-step bit-by-bit square root of
// the axis length followed by the FRAC_BITS+1 step restoring divider that normalises the
// axis. The angle is wrapped into [-pi, pi], folded into [-pi/2, pi/2] and fed to a
// rotation-mode cordic that runs alongside the square root. When out_ready is low with a
// word waiting at the output, the whole pipeline holds and in_ready drops.
module axis_angle_rotation_matrix_core
  import aarm_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [15:0] angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] rot_00,
  output logic signed [15:0] rot_01,
  output logic signed [15:0] rot_02,
  output logic signed [15:0] rot_10,
  output logic signed [15:0] rot_11,
  output logic signed [15:0] rot_12,
  output logic signed [15:0] rot_20,
  output logic signed [15:0] rot_21,
  output logic signed [15:0] rot_22,
  output logic               zero_axis
);

  localparam int F     = FRAC_BITS;
  localparam int CS    = CORDIC_STAGES;
  localparam int QB    = F + 1;          // quotient bits of the normalising divide
  localparam int NW    = F + 31;         // divider remainder width
  localparam int CW    = F + 3;          // cordic x, y and sin/cos width
  localparam int ZW    = F + 4;          // cordic angle width
  localparam int NBW   = F + 2;          // unit axis component width
  localparam int PW    = 2 * F + 6;      // product width
  localparam int MW    = F + 4;          // matrix entry before output rounding
  localparam int TW    = 34;             // Q29 angle width
  localparam int RW    = 63;             // square root remainder width
  localparam int RTW   = SQRT_STEPS;     // root width
  localparam int DEPTH = 41 + QB;

  // angle rounding from Q29 to Q(F)
  localparam int ZR = (F < 29) ? 29 - F : 0;
  localparam int ZH = (F < 29) ? (1 << (28 - F)) : 0;
  localparam int ZL = (F > 29) ? F - 29 : 0;
  localparam int ZTW = TW + 2;

  // output rounding from Q(F) to Q14
  localparam int OR_SH = (F > 14) ? F - 14 : 0;
  localparam int OR_HF = (F > 14) ? (1 << (F - 15)) : 0;
  localparam int OL_SH = (F < 14) ? 14 - F : 0;
  localparam int OW    = MW + OL_SH + 1;

  localparam logic signed [TW-1:0] PI_T     = TW'(PI_Q29);
  localparam logic signed [TW-1:0] HALFPI_T = TW'(HALFPI_Q29);
  localparam logic signed [TW-1:0] TWOPI_T  = TW'(TWOPI_Q29);
  localparam logic signed [CW-1:0] X0       = CW'(rescale_const(cordic_gain(CS), 30, F));
  localparam logic signed [CW-1:0] ONE_F    = CW'(1) <<< F;
  localparam logic signed [PW-1:0] HALF_P   = PW'(1) <<< (F - 1);

  // pipeline control: every stage moves together
  logic [DEPTH-1:0] vld;
  logic             en;

  assign en        = ~vld[DEPTH-1] | out_ready;
  assign in_ready  = en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // input word capture
  logic signed [15:0] ax, ay, az, ang;

  always_ff @(posedge clk) begin
    if (en) begin
      ax  <= axis_x;
      ay  <= axis_y;
      az  <= axis_z;
      ang <= angle;
    end
  end

  // squares, magnitudes, angle wrap into [-pi, pi]
  logic [30:0]             sqx, sqy, sqz;
  logic [2:0][15:0]        mag1;
  logic [2:0]              sgn1;
  logic                    zero1;
  logic signed [TW-1:0]    tw1;
  logic signed [TW-1:0]    t_raw;

  assign t_raw = TW'(ang) <<< 17;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx     <= 31'(ax * ax);
      sqy     <= 31'(ay * ay);
      sqz     <= 31'(az * az);
      mag1[0] <= ax[15] ? 16'(-ax) : ax;
      mag1[1] <= ay[15] ? 16'(-ay) : ay;
      mag1[2] <= az[15] ? 16'(-az) : az;
      sgn1    <= {az[15], ay[15], ax[15]};
      zero1   <= (ax == 16'sd0) && (ay == 16'sd0) && (az == 16'sd0);
      if (t_raw > PI_T) begin
        tw1 <= t_raw - TWOPI_T;
      end else if (t_raw < -PI_T) begin
        tw1 <= t_raw + TWOPI_T;
      end else begin
        tw1 <= t_raw;
      end
    end
  end

  // shared stage arrays for square root and cordic, index 0 loaded below
  logic [RW-1:0]           sq_rem  [0:SQRT_STEPS];
  logic [RTW-1:0]          sq_root [0:SQRT_STEPS];
  logic signed [CW-1:0]    cx      [0:SQRT_STEPS];
  logic signed [CW-1:0]    cy      [0:SQRT_STEPS];
  logic signed [ZW-1:0]    cz      [0:SQRT_STEPS];
  logic                    neg_d   [0:SQRT_STEPS];
  logic [2:0][15:0]        mag_d   [0:SQRT_STEPS];
  logic [2:0]              sgn_d   [0:SQRT_STEPS];
  logic                    zero_d  [0:SQRT_STEPS];

  // norm, fold to [-pi/2, pi/2], round angle
  logic [31:0]             norm2;
  logic signed [TW-1:0]    t_fold;
  logic                    fold_neg;
  logic signed [ZTW-1:0]   z_round;

  assign norm2 = 32'(sqx) + 32'(sqy) + 32'(sqz);

  always_comb begin
    t_fold   = tw1;
    fold_neg = 1'b0;
    if (tw1 > HALFPI_T) begin
      t_fold   = tw1 - PI_T;
      fold_neg = 1'b1;
    end else if (tw1 < -HALFPI_T) begin
      t_fold   = tw1 + PI_T;
      fold_neg = 1'b1;
    end
    z_round = ((ZTW'(t_fold) + ZTW'(ZH)) >>> ZR) <<< ZL;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_rem[0]  <= RW'(norm2) << 30;
      sq_root[0] <= '0;
      cx[0]      <= X0;
      cy[0]      <= '0;
      cz[0]      <= ZW'(z_round);
      neg_d[0]   <= fold_neg;
      mag_d[0]   <= mag1;
      sgn_d[0]   <= sgn1;
      zero_d[0]  <= zero1;
    end
  end

  // one root bit per stage; cordic rotations share the first stages
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq
    localparam int B = SQRT_STEPS - 1 - k;
    logic [RW-1:0] trial;

    assign trial = (RW'(sq_root[k]) << (B + 1)) + (RW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_rem[k] >= trial) begin
          sq_rem[k+1]  <= sq_rem[k] - trial;
          sq_root[k+1] <= sq_root[k] | (RTW'(1) << B);
        end else begin
          sq_rem[k+1]  <= sq_rem[k];
          sq_root[k+1] <= sq_root[k];
        end
        neg_d[k+1]  <= neg_d[k];
        mag_d[k+1]  <= mag_d[k];
        sgn_d[k+1]  <= sgn_d[k];
        zero_d[k+1] <= zero_d[k];
      end
    end

    if (k < CS) begin : g_rot
      localparam logic signed [ZW-1:0] DA = ZW'(rescale_const(ATAN_Q30[k], 30, F));
      logic signed [CW-1:0] dx, dy;

      assign dx = cy[k] >>> k;
      assign dy = cx[k] >>> k;

      always_ff @(posedge clk) begin
        if (en) begin
          if (!cz[k][ZW-1]) begin
            cx[k+1] <= cx[k] - dx;
            cy[k+1] <= cy[k] + dy;
            cz[k+1] <= cz[k] - DA;
          end else begin
            cx[k+1] <= cx[k] + dx;
            cy[k+1] <= cy[k] - dy;
            cz[k+1] <= cz[k] + DA;
          end
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          cx[k+1] <= cx[k];
          cy[k+1] <= cy[k];
          cz[k+1] <= cz[k];
        end
      end
    end
  end

  // normalising divide: n_i = round(|a_i| * 2^(F+15) / r)
  logic [2:0][NW-1:0]      dv_rem [0:QB];
  logic [2:0][QB-1:0]      dv_q   [0:QB];
  logic [RTW-1:0]          dv_d   [0:QB];
  logic signed [CW-1:0]    dv_c   [0:QB];
  logic signed [CW-1:0]    dv_s   [0:QB];
  logic [2:0]              dv_sgn [0:QB];
  logic                    dv_zero[0:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= (NW'(mag_d[SQRT_STEPS][i]) << (F + 15))
                        + NW'(sq_root[SQRT_STEPS] >> 1);
      end
      dv_q[0]    <= '0;
      dv_d[0]    <= sq_root[SQRT_STEPS];
      dv_c[0]    <= neg_d[SQRT_STEPS] ? -cx[SQRT_STEPS] : cx[SQRT_STEPS];
      dv_s[0]    <= neg_d[SQRT_STEPS] ? -cy[SQRT_STEPS] : cy[SQRT_STEPS];
      dv_sgn[0]  <= sgn_d[SQRT_STEPS];
      dv_zero[0] <= zero_d[SQRT_STEPS];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_dv
    localparam int B = QB - 1 - j;
    logic [NW-1:0] dsh;

    assign dsh = NW'(dv_d[j]) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (dv_rem[j][i] >= dsh) begin
            dv_rem[j+1][i] <= dv_rem[j][i] - dsh;
            dv_q[j+1][i]   <= dv_q[j][i] | (QB'(1) << B);
          end else begin
            dv_rem[j+1][i] <= dv_rem[j][i];
            dv_q[j+1][i]   <= dv_q[j][i];
          end
        end
        dv_d[j+1]    <= dv_d[j];
        dv_c[j+1]    <= dv_c[j];
        dv_s[j+1]    <= dv_s[j];
        dv_sgn[j+1]  <= dv_sgn[j];
        dv_zero[j+1] <= dv_zero[j];
      end
    end
  end

  // signed unit axis
  logic signed [NBW-1:0]   n_p [3];
  logic signed [CW-1:0]    c_p, s_p;
  logic                    zero_p;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n_p[i] <= dv_sgn[QB][i] ? -signed'({1'b0, dv_q[QB][i]})
                                :  signed'({1'b0, dv_q[QB][i]});
      end
      c_p    <= dv_c[QB];
      s_p    <= dv_s[QB];
      zero_p <= dv_zero[QB];
    end
  end

  // products s*n_i and n_i*n_j; nn order 00 11 22 01 02 12
  logic signed [PW-1:0]    sn_m [3];
  logic signed [PW-1:0]    nn_m [6];
  logic signed [CW-1:0]    omc_m, c_m;
  logic                    zero_m;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sn_m[i] <= s_p * n_p[i];
      end
      nn_m[0] <= n_p[0] * n_p[0];
      nn_m[1] <= n_p[1] * n_p[1];
      nn_m[2] <= n_p[2] * n_p[2];
      nn_m[3] <= n_p[0] * n_p[1];
      nn_m[4] <= n_p[0] * n_p[2];
      nn_m[5] <= n_p[1] * n_p[2];
      omc_m   <= ONE_F - c_p;
      c_m     <= c_p;
      zero_m  <= zero_p;
    end
  end

  // round products back to Q(F)
  logic signed [CW-1:0]    sn_r [3];
  logic signed [NBW-1:0]   nn_r [6];
  logic signed [CW-1:0]    omc_r, c_r;
  logic                    zero_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sn_r[i] <= CW'((sn_m[i] + HALF_P) >>> F);
      end
      for (int i = 0; i < 6; i++) begin
        nn_r[i] <= NBW'((nn_m[i] + HALF_P) >>> F);
      end
      omc_r  <= omc_m;
      c_r    <= c_m;
      zero_r <= zero_m;
    end
  end

  // (1 - c) * n_i n_j
  logic signed [PW-1:0]    on_m [6];
  logic signed [CW-1:0]    sn_q [3];
  logic signed [CW-1:0]    c_q;
  logic                    zero_q;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        on_m[i] <= omc_r * nn_r[i];
      end
      sn_q   <= sn_r;
      c_q    <= c_r;
      zero_q <= zero_r;
    end
  end

  // sum the two terms of each entry
  logic signed [MW-1:0]    on_r [6];
  logic signed [MW-1:0]    mat  [9];
  logic                    zero_s;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      on_r[i] = MW'((on_m[i] + HALF_P) >>> F);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat[0] <= MW'(c_q) + on_r[0];
      mat[1] <= on_r[3] - MW'(sn_q[2]);
      mat[2] <= on_r[4] + MW'(sn_q[1]);
      mat[3] <= on_r[3] + MW'(sn_q[2]);
      mat[4] <= MW'(c_q) + on_r[1];
      mat[5] <= on_r[5] - MW'(sn_q[0]);
      mat[6] <= on_r[4] - MW'(sn_q[1]);
      mat[7] <= on_r[5] + MW'(sn_q[0]);
      mat[8] <= MW'(c_q) + on_r[2];
      zero_s <= zero_q;
    end
  end

  // round to Q2.14, saturate, zero matrix for a null axis
  logic signed [OW-1:0]    q14 [9];
  logic signed [15:0]      res [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      q14[i] = ((OW'(mat[i]) + OW'(OR_HF)) >>> OR_SH) <<< OL_SH;
      if (zero_s) begin
        res[i] = '0;
      end else if (q14[i] > OW'(ONE_Q14)) begin
        res[i] = 16'(ONE_Q14);
      end else if (q14[i] < -OW'(ONE_Q14)) begin
        res[i] = -16'(ONE_Q14);
      end else begin
        res[i] = 16'(q14[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_00    <= res[0];
      rot_01    <= res[1];
      rot_02    <= res[2];
      rot_10    <= res[3];
      rot_11    <= res[4];
      rot_12    <= res[5];
      rot_20    <= res[6];
      rot_21    <= res[7];
      rot_22    <= res[8];
      zero_axis <= zero_s;
    end
  end

endmodule

// ----- tb/sv/rot_matrix_checker.sv -----
`timescale 1ns / 1ps
module rot_matrix_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic signed [15:0] angle,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] rot_00,
  input  logic signed [15:0] rot_01,
  input  logic signed [15:0] rot_02,
  input  logic signed [15:0] rot_10,
  input  logic signed [15:0] rot_11,
  input  logic signed [15:0] rot_12,
  input  logic signed [15:0] rot_20,
  input  logic signed [15:0] rot_21,
  input  logic signed [15:0] rot_22,
  input  logic               zero_axis,
  output int                 fail_count,
  output int                 pending
);
  import aarm_pkg::*;

  typedef struct packed {
    logic [8:0][15:0] ent;
    logic             zflag;
  } matrix_t;

  localparam int FB = FRAC_BITS_DEF;
  localparam int NST = CORDIC_STAGES_DEF;

  matrix_t matrix_q[$];

  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd(longint v, int from, int to);
    longint one;
    one = 1;
    if (to >= from) return v * (one <<< (to - from));
    return fshr(v + (one <<< (from - to - 1)), from - to);
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint one;
    one = 1;
    return fshr(a * b + (one <<< (FB - 1)), FB);
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [15:0] clamp_q14(longint v);
    longint q;
    q = rnd(v, FB, 14);
    if (q > 16384) q = 16384;
    if (q < -16384) q = -16384;
    return q[15:0];
  endfunction

  function automatic matrix_t rodrigues(logic signed [15:0] ax, logic signed [15:0] ay,
                                        logic signed [15:0] az, logic signed [15:0] ang);
    matrix_t res;
    longint a[3], n[3], m[9];
    longint t, x, y, z, gain, dx, dy, c, s, omc, one;
    longint unsigned norm2, r, mag, q;
    bit flip;
    a[0] = ax; a[1] = ay; a[2] = az;
    one = 1;
    res = '0;
    norm2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
    if (norm2 == 0) begin
      res.zflag = 1'b1;
      return res;
    end
    r = int_sqrt(norm2 << 30);
    for (int i = 0; i < 3; i++) begin
      mag = longint'(a[i] < 0 ? -a[i] : a[i]) << (FB + 15);
      q = (mag + (r >> 1)) / r;
      n[i] = a[i] < 0 ? -longint'(q) : longint'(q);
    end
    // angle wrap and fold, then rotation-mode cordic
    t = longint'(ang) * 131072;
    flip = 0;
    if (t > PI_Q29) t -= TWOPI_Q29;
    else if (t < -PI_Q29) t += TWOPI_Q29;
    if (t > HALFPI_Q29) begin t -= PI_Q29; flip = 1; end
    else if (t < -HALFPI_Q29) begin t += PI_Q29; flip = 1; end
    z = rnd(t, 29, FB);
    gain = KINF_Q30 + fshr(KTWOTHIRDS_Q30 + (one <<< (2 * NST - 1)), 2 * NST);
    x = rnd(gain, 30, FB);
    y = 0;
    for (int i = 0; i < NST && i < 24; i++) begin
      dx = fshr(y, i);
      dy = fshr(x, i);
      if (z >= 0) begin x -= dx; y += dy; z -= rnd(ATAN_Q30[i], 30, FB); end
      else begin x += dx; y -= dy; z += rnd(ATAN_Q30[i], 30, FB); end
    end
    if (flip) begin x = -x; y = -y; end
    c = x; s = y;
    omc = (one <<< FB) - c;
    m[0] = c;              m[1] = -qmul(s, n[2]); m[2] = qmul(s, n[1]);
    m[3] = qmul(s, n[2]);  m[4] = c;              m[5] = -qmul(s, n[0]);
    m[6] = -qmul(s, n[1]); m[7] = qmul(s, n[0]);  m[8] = c;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        m[i * 3 + j] += qmul(omc, qmul(n[i], n[j]));
    for (int k = 0; k < 9; k++) res.ent[k] = clamp_q14(m[k]);
    return res;
  endfunction

  logic [8:0][15:0] got;
  assign got = {rot_22, rot_21, rot_20, rot_12, rot_11, rot_10, rot_02, rot_01, rot_00};
  assign pending = matrix_q.size();

  always @(posedge clk) begin
    matrix_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        matrix_q.push_back(rodrigues(axis_x, axis_y, axis_z, angle));
      if (out_valid && out_ready) begin
        if (matrix_q.size() == 0) begin
          $display("%0t: unexpected word, got zero_axis %0d", $time, zero_axis);
          fail_count <= fail_count + 1;
        end else begin
          want = matrix_q.pop_front();
          if (want.zflag !== zero_axis || want.ent !== got) begin
            $display("%0t: mismatch zero_axis exp %0d got %0d", $time, want.zflag, zero_axis);
            for (int k = 0; k < 9; k++)
              if (want.ent[k] !== got[k])
                $display("%0t:   rot_%0d%0d exp %0d got %0d", $time, k / 3, k % 3,
                         $signed(want.ent[k]), $signed(got[k]));
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, zero_axis;
  logic signed [15:0] axis_x, axis_y, axis_z, angle;
  logic signed [15:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22;
  int fail_count, pending;
  int send_idle_pct, recv_stall_pct; // idling odds for the current phase
  bit long_hold;                     // receiver held off by the pressure phase
  int quiet_cycles;

  axis_angle_rotation_matrix_core u_top (.*);

  rot_matrix_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off while long_hold is set
  initial begin
    out_ready = 0;
    forever begin
      @(posedge clk);
      out_ready <= !long_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // offer one word and hold it until it is taken; valid is left high when the task returns
  task automatic send_word(logic signed [15:0] x, y, z, a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    axis_x <= x; axis_y <= y; axis_z <= z; angle <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // mostly small axes, some full-range noise and extreme components; angles are full range
  task automatic send_random;
    logic signed [15:0] x, y, z;
    case ($urandom_range(3))
      0: begin x = 16'($urandom); y = 16'($urandom); z = 16'($urandom); end
      1: begin
        x = 16'($signed($urandom_range(8)) - 4);
        y = 16'($signed($urandom_range(8)) - 4);
        z = 16'($signed($urandom_range(8)) - 4);
      end
      2: begin x = 16'($urandom); y = 0; z = ($urandom_range(1) ? 16'sd0 : 16'(-32768)); end
      default: begin
        x = 16'($signed($urandom_range(2000)) - 1000);
        y = 16'($signed($urandom_range(2000)) - 1000);
        z = 16'($signed($urandom_range(2000)) - 1000);
      end
    endcase
    send_word(x, y, z, 16'($urandom));
  endtask

  task automatic drain;
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst = 1; in_valid = 0; long_hold = 0;
    axis_x = 0; axis_y = 0; axis_z = 0; angle = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: zero axis, unit axes, extreme components, angle wrap edges
    send_word(0, 0, 0, 16'sd1000);
    send_word(0, 0, 0, 0);
    send_word(1, 0, 0, 16'sd6434);
    send_word(0, 1, 0, -16'sd6434);
    send_word(0, 0, 1, 16'sd12868);
    send_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_word(16'sh8000, 0, 0, 16'sd12867);
    send_word(0, 16'sh7fff, 0, -16'sd12868);
    send_word(0, 0, -1, 16'sd6433);
    send_word(-1, -1, -1, -16'sd6433);
    send_word(3, 4, 0, 16'sd3217);
    send_word(1, 1, 0, 16'sd25736);
    send_word(-5, 12, 0, -16'sd25736);
    send_word(16'sh5555, 16'shaaaa, 16'sh7fff, 16'sh5555);
    send_word(1, 2, 3, 16'shffff);
    send_word(1, 2, 3, 1);
    send_word(0, 0, 16'sh8000, 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 51 : (ph == 3) ? 26 : 0;
      recv_stall_pct = (ph == 2) ? 51 : (ph == 3) ? 26 : 0;
      for (int i = 0; i < 110; i++) send_random();
      // sender pauses until all words are back
      drain();
    end

    // pressure: hold the receiver off while words keep coming
    send_idle_pct = 0; recv_stall_pct = 0;
    long_hold = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
      for (int i = 0; i < 70; i++) send_random();
    join
    drain();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ----- axis_angle_rotation_matrix_core.f -----
design/aarm_pkg.sv
design/axis_angle_rotation_matrix_core.sv
tb/sv/rot_matrix_checker.sv
tb/sv/tb.sv
